// ----- design/frb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frb_pkg;

  // fixed field widths of the flit and result items
  localparam int WORD_W = 64;
  localparam int VC_W   = 3;
  localparam int ID_W   = 6;
  localparam int STAT_W = 2;

  // default build parameters
  localparam int NUM_SLOTS_DEF  = 8;
  localparam int MAX_FLITS_DEF  = 16;
  localparam int FLIT_WIDTH_DEF = 64;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_WORD     = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // one incoming flit
  typedef struct packed {
    logic [WORD_W-1:0] flit_data;
    logic              flit_is_tail;
    logic [VC_W-1:0]   virtual_channel;
    logic [ID_W-1:0]   source_id;
    logic [ID_W-1:0]   destination_id;
  } flit_t;

  // one result word
  typedef struct packed {
    logic [WORD_W-1:0] packet_word;
    logic              word_last;
    logic [VC_W-1:0]   packet_channel;
    logic [ID_W-1:0]   packet_source;
    logic [ID_W-1:0]   packet_destination;
    logic [STAT_W-1:0] result_status;
  } result_t;

endpackage

`default_nettype wire

// ----- design/frb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frb_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/flit_reassembly_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// flit      in         start high, busy low      flit      (frb_pkg::flit_t)
// result    out        result_valid, one cycle   result    (frb_pkg::result_t)
//
// the slot scan does one owner compare per cycle on a single comparator and
// stops early at the slot the source already owns; a decide state follows,
// and a tail then reads its n stored words from the word RAM, one per cycle.
// busy stays high until the item is through, so no new flit is taken before.
// results appear in the cycle after the RAM read and cannot be stalled.
// rst is synchronous and frees every slot; the word RAM needs no clearing.

module flit_reassembly_buffer #(
  parameter int NUM_SLOTS  = frb_pkg::NUM_SLOTS_DEF,
  parameter int MAX_FLITS  = frb_pkg::MAX_FLITS_DEF,
  parameter int FLIT_WIDTH = frb_pkg::FLIT_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire frb_pkg::flit_t  flit,
  output logic                 result_valid,
  output frb_pkg::result_t     result
);

  import frb_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FILL_W = $clog2(MAX_FLITS + 1);
  localparam int DEPTH  = NUM_SLOTS * MAX_FLITS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DRAIN
  } state_t;

  state_t state;

  // slot table
  logic [NUM_SLOTS-1:0] in_use;
  logic [ID_W-1:0]      owner [NUM_SLOTS];
  logic [FILL_W-1:0]    fill  [NUM_SLOTS];

  // item and scan registers
  flit_t             cur;
  logic [SLOT_W-1:0] idx;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;

  // drain registers
  logic [SLOT_W-1:0] drn_slot;
  logic [FILL_W-1:0] drn_cnt;
  logic [FILL_W-1:0] rd_idx;

  // output registers
  status_t res_status;
  logic    res_last;

  // slot selection and base address signals
  logic              sel_ok;
  logic [SLOT_W-1:0] sel_slot;
  logic [FILL_W-1:0] sel_fill;
  logic              sel_full;
  logic [ADDR_W-1:0] sel_base;
  logic [ADDR_W-1:0] drn_base;

  // ram ports
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [FLIT_WIDTH-1:0] ram_rdata;

  // one compare of the scan: slot idx owned by this source
  logic scan_match;
  logic scan_free;
  logic scan_end;

  assign scan_match = in_use[idx] && (owner[idx] == cur.source_id);
  assign scan_free  = !in_use[idx];
  assign scan_end   = (idx == SLOT_W'(NUM_SLOTS - 1));

  // slot chosen for the item: own slot first, else lowest free slot
  always_comb begin
    sel_ok   = hit || free_found;
    sel_slot = hit ? hit_slot : free_slot;
    sel_fill = hit ? fill[hit_slot] : '0;
    sel_full = (sel_fill == FILL_W'(MAX_FLITS));
    sel_base = ADDR_W'(sel_slot) * ADDR_W'(MAX_FLITS);
    drn_base = ADDR_W'(drn_slot) * ADDR_W'(MAX_FLITS);
  end

  // word ram controls
  always_comb begin
    ram_we    = (state == S_DECIDE) && sel_ok && !sel_full;
    ram_waddr = sel_base + ADDR_W'(sel_fill);
    ram_re    = (state == S_DRAIN);
    ram_raddr = drn_base + ADDR_W'(rd_idx);
  end

  frb_ram #(
    .WIDTH (FLIT_WIDTH),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_words (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cur.flit_data[FLIT_WIDTH-1:0]),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // sequencer, slot table and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_use       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur        <= flit;
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_match) begin
            hit      <= 1'b1;
            hit_slot <= idx;
            state    <= S_DECIDE;
          end else begin
            if (scan_free && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= idx;
            end
            if (scan_end) begin
              state <= S_DECIDE;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        S_DECIDE: begin
          if (!sel_ok) begin
            // pool exhausted: drop with an error
            result_valid <= 1'b1;
            res_status   <= ST_NO_SLOT;
            res_last     <= 1'b1;
            state        <= S_IDLE;
          end else if (sel_full) begin
            // slot full: drop, free it on a tail
            result_valid <= 1'b1;
            res_status   <= ST_OVERFLOW;
            res_last     <= 1'b1;
            if (cur.flit_is_tail) begin
              in_use[sel_slot] <= 1'b0;
              fill[sel_slot]   <= '0;
            end
            state <= S_IDLE;
          end else if (cur.flit_is_tail) begin
            // tail stored: release slot and read it out
            in_use[sel_slot] <= 1'b0;
            fill[sel_slot]   <= '0;
            drn_slot         <= sel_slot;
            drn_cnt          <= sel_fill + FILL_W'(1);
            rd_idx           <= '0;
            state            <= S_DRAIN;
          end else begin
            // word stored, slot claimed if new
            in_use[sel_slot] <= 1'b1;
            owner[sel_slot]  <= cur.source_id;
            fill[sel_slot]   <= sel_fill + FILL_W'(1);
            state            <= S_IDLE;
          end
        end
        S_DRAIN: begin
          result_valid <= 1'b1;
          res_status   <= ST_WORD;
          res_last     <= (rd_idx == drn_cnt - FILL_W'(1));
          rd_idx       <= rd_idx + FILL_W'(1);
          if (rd_idx == drn_cnt - FILL_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // result item assembly
  always_comb begin
    result.packet_word        = (res_status == ST_WORD) ? WORD_W'(ram_rdata) : '0;
    result.word_last          = res_last;
    result.packet_channel     = cur.virtual_channel;
    result.packet_source      = cur.source_id;
    result.packet_destination = cur.destination_id;
    result.result_status      = res_status;
  end

endmodule

`default_nettype wire
